// ===== rtl/tvs_pkg.sv =====
// Shared types, constants and step tables for the timed valve sequencer.
package tvs_pkg;

	localparam int unsigned TIME_BITS  = 32;
	localparam int unsigned VALVE_BITS = 13;
	localparam int unsigned MAX_STEPS  = 8;
	localparam int unsigned STEP_BITS  = 3;

	// Both sequences have four steps, which is below MAX_STEPS.
	localparam logic [STEP_BITS-1:0] SEQ_LEN = STEP_BITS'(4);

	localparam logic [1:0] SEQ_NONE = 2'd0;
	localparam logic [1:0] SEQ_ID_A = 2'd1;
	localparam logic [1:0] SEQ_ID_B = 2'd2;

	typedef enum logic [1:0] {
		MODE_MANUAL = 2'd0,
		MODE_AUTO   = 2'd1,
		MODE_SEQ_A  = 2'd2,
		MODE_SEQ_B  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DELTA,
		ST_SCAN,
		ST_REMAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                  auto_req;
		logic                  start_req;
		logic                  select_a;
		logic                  select_b;
		logic [VALVE_BITS-1:0] manual_valves;
		logic [TIME_BITS-1:0]  now_ms;
	} in_t;

	typedef struct packed {
		logic                  drive_valid;
		logic [VALVE_BITS-1:0] valve_drive;
		logic [1:0]            mode_code;
		logic [STEP_BITS-1:0]  step_report;
		logic [1:0]            seq_report;
		logic [TIME_BITS-1:0]  ms_to_next;
	} out_t;

	// Start time of step k; entry SEQ_LEN is the end time of the sequence.
	function automatic logic [TIME_BITS-1:0] seq_start(input logic is_b,
			input logic [STEP_BITS-1:0] k);
		logic [TIME_BITS-1:0] t;
		t = '0;
		if (is_b) begin
			case (k)
				3'd1:    t = TIME_BITS'(3000);
				3'd2:    t = TIME_BITS'(6000);
				3'd3:    t = TIME_BITS'(9000);
				3'd4:    t = TIME_BITS'(12000);
				default: t = '0;
			endcase
		end else begin
			case (k)
				3'd1:    t = TIME_BITS'(3000);
				3'd2:    t = TIME_BITS'(13000);
				3'd3:    t = TIME_BITS'(16000);
				3'd4:    t = TIME_BITS'(18000);
				default: t = '0;
			endcase
		end
		return t;
	endfunction

	function automatic logic [VALVE_BITS-1:0] seq_word(input logic is_b,
			input logic [STEP_BITS-1:0] k);
		logic [VALVE_BITS-1:0] w;
		w = '0;
		if (is_b) begin
			case (k)
				3'd0:    w = VALVE_BITS'(13'h000);
				3'd1:    w = VALVE_BITS'(13'h001);
				3'd2:    w = VALVE_BITS'(13'h008);
				3'd3:    w = VALVE_BITS'(13'h009);
				default: w = '0;
			endcase
		end else begin
			case (k)
				3'd0:    w = VALVE_BITS'(13'h006);
				3'd1:    w = VALVE_BITS'(13'h036);
				3'd2:    w = VALVE_BITS'(13'h1C9);
				3'd3:    w = VALVE_BITS'(13'h0C0);
				default: w = '0;
			endcase
		end
		return w;
	endfunction

endpackage

// ===== rtl/timed_valve_sequencer_top.sv =====
// Timed valve sequencer: mode machine and step scan over one shared subtractor.
//
// Usage: one input transfer on in_valid/in_ready is one control pass (command
// bits, manual valve word, millisecond time). Every pass yields exactly one
// result transfer on out_valid/out_ready: drive flag, valve word, mode, step,
// last sequence and milliseconds to the next step.
// The block works on one pass at a time; in_ready is high only when idle.
// A pass whose updated mode is manual or automatic goes from ST_DELTA straight
// to ST_DONE, which loads its result once the output register is free. A sequence
// pass scans the step table one entry per cycle through the single 32-bit
// subtractor, then, unless the sequence has ended, forms the remaining time with
// the same unit in ST_REMAIN before its result is loaded. With a ready receiver,
// in_ready returns in the cycle after the result is loaded, for the next pass.
// The result sits in an output register, so a new pass may be accepted and
// worked on while the previous result still waits; when the receiver stalls
// and the next result is ready, the block holds it and stops taking input.
// Reset puts the mode in manual, clears the start stamp, step, sequence and
// remaining time, and empties the output register.
module timed_valve_sequencer_top
	import tvs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	state_t state_q, state_nx;
	mode_t  mode_q, mode_nx;
	logic   enter_seq;

	logic [TIME_BITS-1:0]  stamp_q;
	logic [STEP_BITS-1:0]  step_q;
	logic [1:0]            active_q;
	logic [TIME_BITS-1:0]  remain_q;
	logic [STEP_BITS-1:0]  idx_q;
	logic                  dv_q;
	logic                  out_valid_q;

	in_t                   in_q;
	logic [TIME_BITS-1:0]  delta_q;
	logic [VALVE_BITS-1:0] drive_q;
	out_t                  out_q;

	// Shared subtractor.
	logic [TIME_BITS-1:0] sub_a, sub_b;
	logic [TIME_BITS:0]   sub_full;
	logic                 sub_borrow;
	logic [TIME_BITS-1:0] sub_diff;

	logic                 is_b;
	logic [STEP_BITS-1:0] idx_inc;
	logic                 step_passed;
	logic                 out_free;
	out_t                 result;

	assign is_b     = (mode_q == MODE_SEQ_B);
	assign idx_inc  = idx_q + STEP_BITS'(1);
	assign out_free = !out_valid_q || out_ready;

	assign sub_full    = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_borrow  = sub_full[TIME_BITS];
	assign sub_diff    = sub_full[TIME_BITS-1:0];
	assign step_passed = !sub_borrow;

	// Mode update from the command bits of the pass held in in_q.
	always_comb begin
		mode_nx   = mode_q;
		enter_seq = 1'b0;
		case (mode_q)
			MODE_MANUAL: begin
				if (in_q.auto_req) mode_nx = MODE_AUTO;
			end
			MODE_AUTO: begin
				if (in_q.start_req && (in_q.select_a != in_q.select_b)) begin
					enter_seq = 1'b1;
					mode_nx   = in_q.select_a ? MODE_SEQ_A : MODE_SEQ_B;
				end
				if (!in_q.auto_req) mode_nx = MODE_MANUAL;
			end
			MODE_SEQ_A: begin
				if (!in_q.select_a || in_q.select_b) mode_nx = MODE_AUTO;
				if (!in_q.auto_req) mode_nx = MODE_MANUAL;
			end
			MODE_SEQ_B: begin
				if (!in_q.select_b || in_q.select_a) mode_nx = MODE_AUTO;
				if (!in_q.auto_req) mode_nx = MODE_MANUAL;
			end
			default: mode_nx = MODE_MANUAL;
		endcase
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nx = ST_DELTA;
			end
			ST_DELTA: begin
				if (mode_nx == MODE_SEQ_A || mode_nx == MODE_SEQ_B) state_nx = ST_SCAN;
				else state_nx = ST_DONE;
			end
			ST_SCAN: begin
				if (!step_passed) state_nx = ST_REMAIN;
				else if (idx_inc == SEQ_LEN) state_nx = ST_DONE;
			end
			ST_REMAIN: state_nx = ST_DONE;
			ST_DONE: begin
				if (out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// State outputs: handshake and subtractor operands.
	always_comb begin
		in_ready = 1'b0;
		sub_a    = delta_q;
		sub_b    = seq_start(is_b, idx_inc);
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_DELTA: begin
				// A sequence entered in this pass starts at elapsed time zero.
				sub_a = in_q.now_ms;
				sub_b = enter_seq ? in_q.now_ms : stamp_q;
			end
			ST_SCAN: begin
				sub_a = delta_q;
				sub_b = seq_start(is_b, idx_inc);
			end
			ST_REMAIN: begin
				sub_a = seq_start(is_b, idx_inc);
				sub_b = delta_q;
			end
			ST_DONE: in_ready = 1'b0;
			default: in_ready = 1'b0;
		endcase
	end

	always_comb begin
		result.drive_valid = dv_q;
		result.valve_drive = dv_q ? drive_q : '0;
		result.mode_code   = mode_q;
		result.step_report = (mode_q == MODE_SEQ_A || mode_q == MODE_SEQ_B) ? step_q : '0;
		result.seq_report  = active_q;
		result.ms_to_next  = remain_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_MANUAL;
			stamp_q     <= '0;
			step_q      <= '0;
			active_q    <= SEQ_NONE;
			remain_q    <= '0;
			idx_q       <= '0;
			dv_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				ST_DELTA: begin
					mode_q <= mode_nx;
					idx_q  <= '0;
					if (enter_seq) stamp_q <= in_q.now_ms;
					case (mode_nx)
						MODE_MANUAL: dv_q <= 1'b1;
						MODE_AUTO: begin
							dv_q     <= 1'b0;
							step_q   <= '0;
							active_q <= SEQ_NONE;
							remain_q <= '0;
						end
						MODE_SEQ_A: active_q <= SEQ_ID_A;
						MODE_SEQ_B: active_q <= SEQ_ID_B;
						default: dv_q <= 1'b0;
					endcase
				end
				ST_SCAN: begin
					if (step_passed) begin
						idx_q <= idx_inc;
						// Past the end time: the sequence finishes this pass.
						if (idx_inc == SEQ_LEN) begin
							step_q <= SEQ_LEN;
							mode_q <= MODE_AUTO;
							dv_q   <= 1'b0;
						end
					end else begin
						step_q <= idx_q;
					end
				end
				ST_REMAIN: begin
					remain_q <= sub_diff;
					dv_q     <= 1'b1;
				end
				default: begin
				end
			endcase
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) in_q <= in_data;
		if (state_q == ST_DELTA) begin
			delta_q <= sub_diff;
			drive_q <= in_q.manual_valves;
		end
		if (state_q == ST_REMAIN) drive_q <= seq_word(is_b, idx_q);
		if (state_q == ST_DONE && out_free) out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/tvs_checker.sv =====
// Port-level checks for the timed valve sequencer, bound to its top level.
module tvs_checker
	import tvs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	// A stalled result must stay put until it is transferred.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// One pass at a time: after an input transfer the block is busy.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a pass is in progress");

	a_no_drive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.drive_valid |-> out_data.valve_drive == '0)
		else $error("valve word shown without drive");

	a_manual_drives: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.mode_code == MODE_MANUAL
			|-> out_data.drive_valid && out_data.step_report == '0)
		else $error("manual pass without drive or with a step");

	a_auto_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.mode_code == MODE_AUTO
			|-> !out_data.drive_valid && out_data.step_report == '0)
		else $error("automatic pass drives valves or shows a step");

endmodule

bind timed_valve_sequencer_top tvs_checker u_tvs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ===== test/tb.sv =====
// Self-checking testbench for the timed valve sequencer top level.
`timescale 1ns / 100ps

module tb;
	import tvs_pkg::*;

	localparam int PASS_TARGET = 1850;
	localparam int STEPS       = 4;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 250;
	localparam int HOLD_AT     = 300;
	localparam int DRAIN       = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	timed_valve_sequencer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// Predicted block state.
	mode_t       pred_mode   = MODE_MANUAL;
	logic [31:0] pred_stamp  = '0;
	logic [2:0]  pred_step   = '0;
	logic [1:0]  pred_seq    = SEQ_NONE;
	logic [31:0] pred_remain = '0;

	in_t  pass_q[$];
	out_t pending_results[$];
	int   pass_total = 1;
	int   pause_at = -1;
	int   passes_sent = 0;
	int   passes_in = 0;
	int   results_out = 0;
	int   fail_count = 0;
	int   quiet_cycles = 0;
	int   hold_left = 0;
	logic hold_done = 1'b0;
	logic in_taken = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] step_edge(logic use_b, int k);
		case (k)
			1:       return 32'd3000;
			2:       return use_b ? 32'd6000 : 32'd13000;
			3:       return use_b ? 32'd9000 : 32'd16000;
			4:       return use_b ? 32'd12000 : 32'd18000;
			default: return 32'd0;
		endcase
	endfunction

	function automatic logic [12:0] step_word(logic use_b, int k);
		if (use_b) begin
			case (k)
				1:       return 13'h001;
				2:       return 13'h008;
				3:       return 13'h009;
				default: return 13'h000;
			endcase
		end
		case (k)
			0:       return 13'h006;
			1:       return 13'h036;
			2:       return 13'h1C9;
			3:       return 13'h0C0;
			default: return 13'h000;
		endcase
	endfunction

	// One control pass: mode update, action on the new mode, then the report.
	function automatic out_t valve_pass(in_t p);
		out_t        r;
		mode_t       nxt;
		logic [31:0] elapsed;
		logic        use_b;
		int          k;
		r = '0;
		nxt = pred_mode;
		case (pred_mode)
			MODE_MANUAL: begin
				if (p.auto_req)
					nxt = MODE_AUTO;
			end
			MODE_AUTO: begin
				// The start time is latched even when manual wins in the same pass.
				if (p.start_req && p.select_a && !p.select_b) begin
					nxt = MODE_SEQ_A;
					pred_stamp = p.now_ms;
				end
				if (p.start_req && !p.select_a && p.select_b) begin
					nxt = MODE_SEQ_B;
					pred_stamp = p.now_ms;
				end
				if (!p.auto_req)
					nxt = MODE_MANUAL;
			end
			MODE_SEQ_A: begin
				if (!p.select_a || p.select_b)
					nxt = MODE_AUTO;
				if (!p.auto_req)
					nxt = MODE_MANUAL;
			end
			default: begin
				if (!p.select_b || p.select_a)
					nxt = MODE_AUTO;
				if (!p.auto_req)
					nxt = MODE_MANUAL;
			end
		endcase
		pred_mode = nxt;

		if (pred_mode == MODE_MANUAL) begin
			r.drive_valid = 1'b1;
			r.valve_drive = p.manual_valves;
		end else if (pred_mode == MODE_AUTO) begin
			pred_step = '0;
			pred_seq = SEQ_NONE;
			pred_remain = '0;
		end else begin
			use_b = (pred_mode == MODE_SEQ_B);
			pred_seq = use_b ? SEQ_ID_B : SEQ_ID_A;
			elapsed = p.now_ms - pred_stamp;
			k = 0;
			while (k < STEPS && step_edge(use_b, k + 1) <= elapsed)
				k++;
			pred_step = 3'(k);
			if (k == STEPS) begin
				pred_mode = MODE_AUTO;
			end else begin
				pred_remain = step_edge(use_b, k + 1) - elapsed;
				r.drive_valid = 1'b1;
				r.valve_drive = step_word(use_b, k);
			end
		end

		r.mode_code = pred_mode;
		r.step_report = (pred_mode == MODE_SEQ_A || pred_mode == MODE_SEQ_B) ? pred_step : '0;
		r.seq_report = pred_seq;
		r.ms_to_next = pred_remain;
		return r;
	endfunction

	task automatic add_pass(bit am, bit st, bit sa, bit sb, logic [12:0] v, logic [31:0] t);
		in_t p;
		p.auto_req = am;
		p.start_req = st;
		p.select_a = sa;
		p.select_b = sb;
		p.manual_valves = v;
		p.now_ms = t;
		pass_q.push_back(p);
	endtask

	function automatic bit coin();
		return 1'($urandom_range(0, 1));
	endfunction

	// A well-formed run: into automatic, start a sequence, let time advance,
	// then leave it by one of the exits.
	task automatic add_episode();
		bit          use_b;
		logic [31:0] base;
		logic [31:0] e;
		int          n;
		int          k;
		use_b = coin();
		if ($urandom_range(0, 3) == 0)
			base = 32'hFFFF_FFFF - $urandom_range(0, 20000);
		else
			base = $urandom();
		add_pass(1, coin(), 0, 0, 13'($urandom()), base - $urandom_range(0, 100));
		add_pass(1, 1, !use_b, use_b, 13'($urandom()), base);
		e = '0;
		n = $urandom_range(2, 10);
		repeat (n) begin
			if ($urandom_range(0, 3) == 0) begin
				k = $urandom_range(1, STEPS);
				if (step_edge(use_b, k) > e)
					e = step_edge(use_b, k) - $urandom_range(0, 1);
			end else begin
				e = e + $urandom_range(0, 3000);
			end
			add_pass(1, coin(), !use_b, use_b, 13'($urandom()), base + e);
		end
		case ($urandom_range(0, 9))
			0: add_pass(0, coin(), coin(), coin(), 13'($urandom()), base + e);
			1: add_pass(1, coin(), 1, 1, 13'($urandom()), base + e);
			2: add_pass(1, coin(), use_b, !use_b, 13'($urandom()), base + e);
			3: add_pass(1, coin(), !use_b, use_b, 13'($urandom()),
				base + e - $urandom_range(1, 5000));
			default: begin
				add_pass(1, coin(), !use_b, use_b, 13'($urandom()),
					base + 32'd12000 + $urandom_range(0, 8000));
				add_pass(1, coin(), !use_b, use_b, 13'($urandom()),
					base + 32'd18000 + $urandom_range(0, 8000));
			end
		endcase
	endtask

	task automatic add_directed();
		add_pass(0, 0, 0, 0, 13'h1FFF, 32'h0000_0000);
		add_pass(0, 1, 1, 1, 13'h0000, 32'hFFFF_FFFF);
		// A start from manual only reaches automatic.
		add_pass(1, 1, 1, 0, 13'h0AAA, 32'd100);
		add_pass(1, 1, 1, 1, 13'h1555, 32'd200);
		add_pass(1, 1, 0, 0, 13'h0001, 32'd300);
		add_pass(1, 1, 1, 0, 13'h1000, 32'd1000);
		add_pass(1, 0, 1, 0, 13'h0000, 32'd3999);
		add_pass(1, 0, 1, 0, 13'h0000, 32'd4000);
		add_pass(1, 0, 1, 0, 13'h0000, 32'd14000);
		add_pass(1, 0, 1, 0, 13'h0000, 32'd17000);
		add_pass(1, 0, 1, 0, 13'h0000, 32'd18999);
		add_pass(1, 0, 1, 0, 13'h0000, 32'd19000);
		add_pass(1, 0, 1, 0, 13'h0000, 32'd19001);
		// Sequence B started just below the clock wrap.
		add_pass(1, 1, 0, 1, 13'h0000, 32'hFFFF_F000);
		add_pass(1, 0, 0, 1, 13'h0000, 32'h0000_0BB7);
		add_pass(1, 0, 1, 1, 13'h0000, 32'h0000_0C00);
		add_pass(1, 1, 0, 1, 13'h0000, 32'd500);
		add_pass(0, 0, 0, 1, 13'h0F0F, 32'd600);
		add_pass(0, 0, 0, 0, 13'h10F0, 32'd700);
		add_pass(1, 0, 0, 0, 13'h0000, 32'd800);
		add_pass(1, 1, 1, 0, 13'h0000, 32'd50000);
		// A clock that runs backwards looks like a very long elapsed time.
		add_pass(1, 0, 1, 0, 13'h0000, 32'd49999);
		add_pass(0, 1, 1, 0, 13'h0000, 32'd60000);
		add_pass(1, 1, 1, 0, 13'h0000, 32'd61000);
		add_pass(1, 1, 1, 0, 13'h0000, 32'd62000);
		add_pass(1, 0, 0, 0, 13'h0000, 32'd63000);
	endtask

	function automatic int phase_now();
		return (passes_in * 4) / pass_total;
	endfunction

	function automatic int sender_idle_pct();
		case (phase_now())
			1:       return 48;
			3:       return 38;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_stall_pct();
		case (phase_now())
			2:       return 48;
			3:       return 38;
			default: return 0;
		endcase
	endfunction

	// Sender: a new pass is offered only after the current one has transferred.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pass_q.size() != 0
						&& !(passes_sent == pause_at && pending_results.size() != 0)
						&& $urandom_range(0, 99) >= sender_idle_pct()) begin
					in_data <= pass_q.pop_front();
					in_valid <= 1'b1;
					passes_sent <= passes_sent + 1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off so that the block backs up.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (!hold_done && results_out >= HOLD_AT) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct());
			end
		end
	end

	task automatic check_result(out_t got);
		out_t want;
		if (pending_results.size() == 0) begin
			$error("result transfer with no pass outstanding: %h", got);
			fail_count++;
			return;
		end
		want = pending_results.pop_front();
		if (got.drive_valid !== want.drive_valid) begin
			$error("drive_valid: expected %0d, actual %0d", want.drive_valid, got.drive_valid);
			fail_count++;
		end
		if (got.valve_drive !== want.valve_drive) begin
			$error("valve_drive: expected %h, actual %h", want.valve_drive, got.valve_drive);
			fail_count++;
		end
		if (got.mode_code !== want.mode_code) begin
			$error("mode_code: expected %0d, actual %0d", want.mode_code, got.mode_code);
			fail_count++;
		end
		if (got.step_report !== want.step_report) begin
			$error("step_report: expected %0d, actual %0d", want.step_report, got.step_report);
			fail_count++;
		end
		if (got.seq_report !== want.seq_report) begin
			$error("seq_report: expected %0d, actual %0d", want.seq_report, got.seq_report);
			fail_count++;
		end
		if (got.ms_to_next !== want.ms_to_next) begin
			$error("ms_to_next: expected %0d, actual %0d", want.ms_to_next, got.ms_to_next);
			fail_count++;
		end
	endtask

	// Monitor: checks result transfers and predicts each accepted pass.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			in_taken <= in_valid && in_ready;
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (out_valid && out_ready) begin
				check_result(out_data);
				results_out++;
			end
			if (in_valid && in_ready) begin
				pending_results.push_back(valve_pass(in_data));
				passes_in++;
			end
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("FAILURE");
		$finish;
	end

	initial begin
		add_directed();
		while (pass_q.size() < PASS_TARGET) begin
			if ($urandom_range(0, 9) < 8)
				add_episode();
			else
				add_pass($urandom_range(0, 3) != 0, coin(), coin(), coin(),
					13'($urandom()), $urandom());
		end
		pass_total = pass_q.size();
		pause_at = pass_total / 2;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (passes_in < pass_total || pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/tvs_pkg.sv
rtl/timed_valve_sequencer_top.sv
rtl/tvs_checker.sv
test/tb.sv
